@@ sv/ksa_pkg.sv @@
// Shared types and codes for the key-to-slot allocator.
package ksa_pkg;

  localparam int unsigned KEY_W      = 32;
  localparam logic [31:0] KEY_INVERT = 32'hFFFF_FFFF;

  // Request codes carried on the request type field
  typedef enum logic [2:0] {
    REQ_MAP        = 3'd0,
    REQ_UNMAP      = 3'd1,
    REQ_MAP_INV    = 3'd2,
    REQ_UNMAP_INV  = 3'd3,
    REQ_DERIVE     = 3'd4
  } req_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_EXISTING  = 3'd0,
    ST_NEW       = 3'd1,
    ST_FULL      = 3'd2,
    ST_UNMAPPED  = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SRC  = 6'b000010,
    S_READ = 6'b000100,
    S_CMP  = 6'b001000,
    S_DONE = 6'b010000,
    S_BAD  = 6'b100000
  } state_t;

  // Flags reported by the scan compare unit
  typedef struct packed {
    logic hit;
    logic empty;
  } scan_flags_t;

endpackage

@@ sv/ksa_table.sv @@
// Slot key memory with per-slot valid bits and a registered read port.
module ksa_table #(
  parameter int SLOT_COUNT = 16,
  parameter int IW         = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [IW-1:0]               rd_addr,
  output logic [ksa_pkg::KEY_W-1:0]   rd_data,
  input  logic                        wr_en,
  input  logic                        wr_set,
  input  logic [IW-1:0]               wr_addr,
  input  logic [ksa_pkg::KEY_W-1:0]   wr_data
);

  logic [ksa_pkg::KEY_W-1:0] mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]     vld_r;
  logic [ksa_pkg::KEY_W-1:0] rd_data_r;
  logic                      rd_vld_r;

  // Write the key store; valid bits mark written slots
  always_ff @(posedge clk) begin
    if (wr_en && wr_set) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= wr_set;
    end
  end

  // Registered read; a slot never written reads as empty
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

@@ sv/ksa_match.sv @@
// Compare unit: records the lowest matching slot and lowest empty slot.
module ksa_match #(
  parameter int IW = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic                       step,
  input  logic [IW-1:0]              idx,
  input  logic [ksa_pkg::KEY_W-1:0]  data,
  input  logic [ksa_pkg::KEY_W-1:0]  key,
  output ksa_pkg::scan_flags_t       flags,
  output logic [IW-1:0]              hit_idx,
  output logic [IW-1:0]              empty_idx
);

  logic          hit_r;
  logic          empty_r;
  logic [IW-1:0] hit_idx_r;
  logic [IW-1:0] empty_idx_r;

  // Keep the first hit and first empty slot seen in the scan
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      hit_r   <= 1'b0;
      empty_r <= 1'b0;
    end else if (step) begin
      if (!hit_r && (data == key)) begin
        hit_r     <= 1'b1;
        hit_idx_r <= idx;
      end
      if (!empty_r && (data == '0)) begin
        empty_r     <= 1'b1;
        empty_idx_r <= idx;
      end
    end
  end

  assign flags.hit   = hit_r;
  assign flags.empty = empty_r;
  assign hit_idx     = hit_idx_r;
  assign empty_idx   = empty_idx_r;

endmodule

@@ sv/key_to_slot_allocator_unit.sv @@
// Top level: request sequencer, table scan and result register.
//
//  Channel   Ports                                   Handshake
//  --------  --------------------------------------  ---------------------------
//  request   in_req_type, in_key, in_slot_index      start high while busy low
//  result    out_slot, out_status                    out_valid, one cycle, no stall
//
// A request scans every slot in turn, reading it (S_READ) and then comparing
// it (S_CMP), then decides and updates the table in S_DONE; a derive first
// reads its source slot in S_SRC. Bad requests finish through S_BAD.
// The result strobes the cycle after the decision; busy is low in that cycle.
// Synchronous reset empties the table at once through its valid bits.
module key_to_slot_allocator_unit #(
  parameter int SLOT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_key,
  input  logic [3:0]  in_slot_index,
  output logic        out_valid,
  output logic [3:0]  out_slot,
  output logic [2:0]  out_status
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

  ksa_pkg::state_t           state_r, state_nxt;
  logic [IW-1:0]             cnt_r, cnt_nxt;
  logic [31:0]               key_r, key_nxt;
  logic                      map_r, map_nxt;
  logic                      out_valid_r;
  logic [3:0]                out_slot_r;
  ksa_pkg::status_t          out_status_r;

  logic                      accept;
  logic                      src_ok;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic [31:0]               rd_data;
  logic                      wr_en;
  logic                      wr_set;
  logic [IW-1:0]             wr_addr;
  ksa_pkg::scan_flags_t      flags;
  logic [IW-1:0]             hit_idx;
  logic [IW-1:0]             empty_idx;

  assign accept = start && !busy;
  assign busy   = (state_r != ksa_pkg::S_IDLE);
  assign src_ok = (32'(in_slot_index) < SLOT_COUNT);

  // Sequence one transaction through source read, scan and decision
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    map_nxt   = map_r;
    case (state_r)
      ksa_pkg::S_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          case (in_req_type)
            ksa_pkg::REQ_MAP: begin
              key_nxt = in_key; map_nxt = 1'b1; state_nxt = ksa_pkg::S_READ;
            end
            ksa_pkg::REQ_UNMAP: begin
              key_nxt = in_key; map_nxt = 1'b0; state_nxt = ksa_pkg::S_READ;
            end
            ksa_pkg::REQ_MAP_INV: begin
              key_nxt   = in_key ^ ksa_pkg::KEY_INVERT;
              map_nxt   = 1'b1;
              state_nxt = ksa_pkg::S_READ;
            end
            ksa_pkg::REQ_UNMAP_INV: begin
              key_nxt   = in_key ^ ksa_pkg::KEY_INVERT;
              map_nxt   = 1'b0;
              state_nxt = ksa_pkg::S_READ;
            end
            ksa_pkg::REQ_DERIVE: begin
              map_nxt   = 1'b1;
              state_nxt = src_ok ? ksa_pkg::S_SRC : ksa_pkg::S_BAD;
            end
            default: state_nxt = ksa_pkg::S_BAD;
          endcase
        end
      end
      ksa_pkg::S_SRC: begin
        key_nxt   = rd_data ^ ksa_pkg::KEY_INVERT;
        state_nxt = ksa_pkg::S_READ;
      end
      ksa_pkg::S_READ: state_nxt = ksa_pkg::S_CMP;
      ksa_pkg::S_CMP: begin
        if (cnt_r == LAST) begin
          state_nxt = ksa_pkg::S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ksa_pkg::S_READ;
        end
      end
      ksa_pkg::S_DONE: state_nxt = ksa_pkg::S_IDLE;
      ksa_pkg::S_BAD:  state_nxt = ksa_pkg::S_IDLE;
      default:         state_nxt = ksa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ksa_pkg::S_IDLE;
      cnt_r   <= '0;
      map_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      map_r   <= map_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  // Read port: source slot at accept of a derive, else the scan address
  assign rd_en   = (accept && (in_req_type == ksa_pkg::REQ_DERIVE) && src_ok)
                 || (state_r == ksa_pkg::S_READ);
  assign rd_addr = (state_r == ksa_pkg::S_READ) ? cnt_r : IW'(in_slot_index);

  // Update the table at the decision step
  always_comb begin
    wr_en   = 1'b0;
    wr_set  = 1'b0;
    wr_addr = empty_idx;
    if (state_r == ksa_pkg::S_DONE) begin
      if (map_r) begin
        wr_en   = !flags.hit && flags.empty;
        wr_set  = 1'b1;
        wr_addr = empty_idx;
      end else begin
        wr_en   = flags.hit;
        wr_set  = 1'b0;
        wr_addr = hit_idx;
      end
    end
  end

  ksa_table #(
    .SLOT_COUNT (SLOT_COUNT),
    .IW         (IW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_set  (wr_set),
    .wr_addr (wr_addr),
    .wr_data (key_r)
  );

  ksa_match #(
    .IW (IW)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (accept),
    .step      (state_r == ksa_pkg::S_CMP),
    .idx       (cnt_r),
    .data      (rd_data),
    .key       (key_r),
    .flags     (flags),
    .hit_idx   (hit_idx),
    .empty_idx (empty_idx)
  );

  // Register the result and strobe it for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ksa_pkg::S_DONE) || (state_r == ksa_pkg::S_BAD);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ksa_pkg::S_BAD) begin
      out_slot_r   <= 4'd0;
      out_status_r <= ksa_pkg::ST_NOT_FOUND;
    end else if (state_r == ksa_pkg::S_DONE) begin
      if (map_r) begin
        if (flags.hit) begin
          out_slot_r   <= 4'(hit_idx);
          out_status_r <= ksa_pkg::ST_EXISTING;
        end else if (flags.empty) begin
          out_slot_r   <= 4'(empty_idx);
          out_status_r <= ksa_pkg::ST_NEW;
        end else begin
          out_slot_r   <= 4'd0;
          out_status_r <= ksa_pkg::ST_FULL;
        end
      end else if (flags.hit) begin
        out_slot_r   <= 4'(hit_idx);
        out_status_r <= ksa_pkg::ST_UNMAPPED;
      end else begin
        out_slot_r   <= 4'd0;
        out_status_r <= ksa_pkg::ST_NOT_FOUND;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_slot   = out_slot_r;
  assign out_status = out_status_r;

endmodule

@@ sv/ksa_checker.sv @@
// Port-level checks for the key-to-slot allocator, bound to the top level.
module ksa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [3:0]  out_slot,
  input logic [2:0]  out_status
);

  // An accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // Busy drops only as the result is strobed
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // A result arrives while the block is already free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  // Results are never strobed back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // Failure codes carry no slot
  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ksa_pkg::ST_FULL) || (out_status == ksa_pkg::ST_NOT_FOUND))
    |-> (out_slot == 4'd0))
    else $error("failure result with nonzero slot");

endmodule

bind key_to_slot_allocator_unit ksa_checker u_ksa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_slot   (out_slot),
  .out_status (out_status)
);

@@ tb/sv/key_to_slot_allocator_unit_tb.sv @@
// Self-checking testbench for the key-to-slot allocator: directed and random requests.
`timescale 1ns / 1ps

module key_to_slot_allocator_unit_tb;

  localparam int SLOTS        = 16;
  localparam int RANDOM_ITEMS = 1530;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
  localparam int POOL_SIZE    = 24;

  typedef struct {
    logic [2:0]  req_type;
    logic [31:0] key;
    logic [3:0]  slot_index;
    int          idle_pct;
  } request_t;

  typedef struct {
    logic [3:0]       slot;
    ksa_pkg::status_t status;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_req_type = '0;
  logic [31:0] in_key = '0;
  logic [3:0]  in_slot_index = '0;
  logic        out_valid;
  logic [3:0]  out_slot;
  logic [2:0]  out_status;

  request_t    request_q[$];
  outcome_t    outcome_q[$];
  logic [31:0] slot_key_mirror[SLOTS];
  logic [31:0] key_pool[POOL_SIZE];
  int          mismatches = 0;
  int          requests_sent = 0;
  int          results_checked = 0;
  int          quiet_cycles = 0;
  int          status_seen[8];

  key_to_slot_allocator_unit #(.SLOT_COUNT(SLOTS)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_key        (in_key),
    .in_slot_index (in_slot_index),
    .out_valid     (out_valid),
    .out_slot      (out_slot),
    .out_status    (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lowest slot in the mirror holding the key, -1 when none
  function automatic int lowest_slot_of(logic [31:0] k);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_key_mirror[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic outcome_t map_key(logic [31:0] k);
    outcome_t r;
    int i;
    i = lowest_slot_of(k);
    if (i >= 0) begin
      r.slot   = 4'(i);
      r.status = ksa_pkg::ST_EXISTING;
    end else begin
      i = lowest_slot_of('0);
      if (i >= 0) begin
        slot_key_mirror[i] = k;
        r.slot   = 4'(i);
        r.status = ksa_pkg::ST_NEW;
      end else begin
        r.slot   = '0;
        r.status = ksa_pkg::ST_FULL;
      end
    end
    return r;
  endfunction

  function automatic outcome_t unmap_key(logic [31:0] k);
    outcome_t r;
    int i;
    i = lowest_slot_of(k);
    if (i >= 0) begin
      slot_key_mirror[i] = '0;
      r.slot   = 4'(i);
      r.status = ksa_pkg::ST_UNMAPPED;
    end else begin
      r.slot   = '0;
      r.status = ksa_pkg::ST_NOT_FOUND;
    end
    return r;
  endfunction

  // Work out the outcome of one request and update the mirror
  function automatic outcome_t predict_outcome(logic [2:0] rt, logic [31:0] k,
                                               logic [3:0] idx);
    outcome_t r;
    r.slot   = '0;
    r.status = ksa_pkg::ST_NOT_FOUND;
    case (rt)
      ksa_pkg::REQ_MAP:       r = map_key(k);
      ksa_pkg::REQ_UNMAP:     r = unmap_key(k);
      ksa_pkg::REQ_MAP_INV:   r = map_key(k ^ ksa_pkg::KEY_INVERT);
      ksa_pkg::REQ_UNMAP_INV: r = unmap_key(k ^ ksa_pkg::KEY_INVERT);
      ksa_pkg::REQ_DERIVE: begin
        if (int'(idx) < SLOTS)
          r = map_key(slot_key_mirror[idx] ^ ksa_pkg::KEY_INVERT);
      end
      default: ;
    endcase
    status_seen[r.status]++;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_request(logic [2:0] rt, logic [31:0] k, logic [3:0] idx, int idle);
    request_t r;
    r.req_type   = rt;
    r.key        = k;
    r.slot_index = idx;
    r.idle_pct   = idle;
    request_q.push_back(r);
  endtask

  // Driver: hold the current transaction until accepted, then present the next
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        outcome_q.push_back(predict_outcome(in_req_type, in_key, in_slot_index));
        requests_sent++;
      end
      if (!(start && busy)) begin
        if (request_q.size() != 0 && $urandom_range(99) >= request_q[0].idle_pct) begin
          start         <= 1'b1;
          in_req_type   <= request_q[0].req_type;
          in_key        <= request_q[0].key;
          in_slot_index <= request_q[0].slot_index;
          void'(request_q.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest predicted outcome
  always @(posedge clk) begin : result_check
    outcome_t due;
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result slot %0d status %0d",
                                out_slot, out_status));
      end else begin
        due = outcome_q.pop_front();
        results_checked++;
        if (out_slot !== due.slot)
          flag_mismatch($sformatf("slot %0d, predicted %0d", out_slot, due.slot));
        if (out_status !== due.status)
          flag_mismatch($sformatf("status %0d, predicted %s", out_status, due.status.name()));
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    // idle percentage per pacing phase; the third phase targets the receiver,
    // which cannot stall, so the sender runs flat out there
    int         phase_idle[4];
    int         idle;
    int         map_pct;
    int         pick;
    logic [2:0] rt;
    logic [31:0] k;
    logic       inverted;

    phase_idle = '{0, 73, 0, 30};
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    foreach (slot_key_mirror[i]) slot_key_mirror[i] = '0;

    // Directed: key zero on an empty table, inversions, derive from empty,
    // filled and own slot, not found, unknown request codes
    queue_request(ksa_pkg::REQ_MAP,       32'h0000_0000, 4'd0, 0);
    queue_request(ksa_pkg::REQ_UNMAP,     32'h0000_0000, 4'd0, 0);
    queue_request(ksa_pkg::REQ_MAP,       32'hFFFF_FFFF, 4'd0, 0);
    queue_request(ksa_pkg::REQ_MAP,       32'hFFFF_FFFF, 4'd0, 0);
    queue_request(ksa_pkg::REQ_MAP_INV,   32'h0000_0000, 4'd0, 0);
    queue_request(ksa_pkg::REQ_UNMAP_INV, 32'hFFFF_FFFF, 4'd0, 0);
    queue_request(ksa_pkg::REQ_MAP,       32'h0000_0001, 4'd0, 0);
    queue_request(ksa_pkg::REQ_MAP,       32'h8000_0000, 4'd0, 0);
    queue_request(ksa_pkg::REQ_MAP_INV,   32'hAAAA_AAAA, 4'd0, 0);
    queue_request(ksa_pkg::REQ_DERIVE,    32'h1234_5678, 4'd15, 0);
    queue_request(ksa_pkg::REQ_DERIVE,    32'h0000_0000, 4'd1, 0);
    queue_request(ksa_pkg::REQ_DERIVE,    32'hFFFF_FFFF, 4'd0, 0);
    queue_request(ksa_pkg::REQ_UNMAP,     32'h1234_5678, 4'd7, 0);
    queue_request(ksa_pkg::REQ_UNMAP_INV, 32'hFFFF_FFFE, 4'd0, 0);
    queue_request(3'(ksa_pkg::REQ_DERIVE) + 3'd1, 32'hFFFF_FFFF, 4'd15, 0);
    queue_request(3'(ksa_pkg::REQ_DERIVE) + 3'd2, 32'h0000_0000, 4'd0, 0);
    queue_request(3'(ksa_pkg::REQ_DERIVE) + 3'd3, 32'h5555_5555, 4'd9, 0);
    queue_request(ksa_pkg::REQ_UNMAP,     32'hFFFF_FFFF, 4'd0, 0);
    queue_request(ksa_pkg::REQ_UNMAP_INV, 32'h7FFF_FFFF, 4'd0, 0);

    // Random: a small key pool keeps hits frequent; map-heavy stretches
    // fill the table, unmap-heavy ones drain it
    idle    = 0;
    map_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0)
        idle = ($urandom_range(99) < 20) ? 0 : phase_idle[(n * 4) / RANDOM_ITEMS];
      if (n % 60 == 0) begin
        pick = $urandom_range(2);
        map_pct = (pick == 0) ? 90 : (pick == 1) ? 50 : 15;
      end
      pick = $urandom_range(99);
      if (pick < 3) rt = 3'(ksa_pkg::REQ_DERIVE) + 3'($urandom_range(3, 1));
      else if ($urandom_range(99) < map_pct) begin
        pick = $urandom_range(99);
        rt = (pick < 55) ? ksa_pkg::REQ_MAP :
             (pick < 80) ? ksa_pkg::REQ_MAP_INV : ksa_pkg::REQ_DERIVE;
      end else begin
        rt = ($urandom_range(1) == 0) ? ksa_pkg::REQ_UNMAP : ksa_pkg::REQ_UNMAP_INV;
      end
      inverted = (rt == ksa_pkg::REQ_MAP_INV) || (rt == ksa_pkg::REQ_UNMAP_INV);
      pick = $urandom_range(99);
      if (pick < 70) k = key_pool[$urandom_range(POOL_SIZE - 1)];
      else if (pick < 80) k = ($urandom_range(1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      else k = $urandom;
      if (inverted && pick < 70) k = k ^ ksa_pkg::KEY_INVERT;
      queue_request(rt, k, 4'($urandom_range(15)), idle);
    end

    // Release reset and let the driver run
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while ((request_q.size() != 0 || start || outcome_q.size() != 0)
           && quiet_cycles < STALL_LIMIT)
      @(posedge clk);

    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      $display("covered %0d requests over four pacing phases, %0d results checked",
               requests_sent, results_checked);
      $display("outcomes: existing %0d, new %0d, full %0d, unmapped %0d, not found %0d",
               status_seen[ksa_pkg::ST_EXISTING], status_seen[ksa_pkg::ST_NEW],
               status_seen[ksa_pkg::ST_FULL], status_seen[ksa_pkg::ST_UNMAPPED],
               status_seen[ksa_pkg::ST_NOT_FOUND]);
      if (mismatches == 0 && outcome_q.size() == 0) begin
        $display("end of test: clean");
      end else begin
        $display("end of test: mismatches");
      end
    end
    $finish;
  end

endmodule
